>>> hw/rtl/rat_pkg.sv
// Shared types and constants for the rational accumulator ALU.
// Used by every module under hw/rtl; no dependencies.
package rat_pkg;

    // Word size of the number format; the limit clamps it to 2..32
    localparam int WORD_BITS = 32;
    localparam int LIM_W     = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);

    // Internal datapath: products and reduced terms fit 64 bits, sums 66 signed
    localparam int DW   = 64;
    localparam int SW   = DW + 2;
    localparam int CW   = $clog2(DW);
    localparam logic [DW-1:0] LIM = (DW'(1) << (LIM_W - 1)) - DW'(1);

    // Opcodes
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_CMP  = 3'd5
    } t_opcode;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Compare codes
    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    // Sequencer states
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_M1   = 13'b0000000000010,
        S_M2   = 13'b0000000000100,
        S_M3   = 13'b0000000001000,
        S_M4   = 13'b0000000010000,
        S_SUM  = 13'b0000000100000,
        S_NEG  = 13'b0000001000000,
        S_RED  = 13'b0000010000000,
        S_GCD  = 13'b0000100000000,
        S_DIVN = 13'b0001000000000,
        S_DIVD = 13'b0010000000000,
        S_CHK  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

endpackage

>>> hw/rtl/rat_mul.sv
// 32x32 unsigned multiplier with registered product.
// Depends on rat_pkg for the product width.
module rat_mul import rat_pkg::*; (
    input  logic          i_clk,
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    output logic [DW-1:0] o_prod
);

    logic [DW-1:0] r_prod;

    // one product per cycle, result in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= DW'(i_a) * DW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/rat_addsub.sv
// Shared signed add/subtract unit used for sums, negation, gcd steps and division.
// Depends on rat_pkg for the datapath width.
module rat_addsub import rat_pkg::*; (
    input  logic [SW-1:0] i_x,
    input  logic [SW-1:0] i_y,
    input  logic          i_sub,
    output logic [SW-1:0] o_sum,
    output logic          o_neg
);

    // x + y or x - y, two's complement
    always_comb begin
        o_sum = i_sub ? (i_x - i_y) : (i_x + i_y);
        o_neg = o_sum[SW-1];
    end

endmodule

>>> hw/rtl/rational_accumulator_alu_unit.sv
// Rational accumulator ALU: sequencer around a shared multiplier and add/sub unit.
// Sequence: load goes straight to reduction; add/sub first passes the multiply, sum
// and negate states; reduction is one binary-gcd step per cycle and, when the gcd is
// not one, two 64-step restoring divisions.
// One transaction at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) sets the accumulator to 0/1 and clears valids.
module rational_accumulator_alu_unit import rat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_operand_num,
    input  logic [30:0] i_operand_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_num,
    output logic [30:0] o_result_den,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status
);

    t_state r_state, n_state;

    // accumulator
    logic [31:0] r_acc_num, n_acc_num;
    logic [30:0] r_acc_den, n_acc_den;

    // latched transaction
    logic [2:0]  r_op, n_op;
    logic [31:0] r_cmag, n_cmag;
    logic        r_cneg, n_cneg;
    logic [30:0] r_d, n_d;
    logic [31:0] r_amag, n_amag;
    logic        r_aneg, n_aneg;
    logic [1:0]  r_st, n_st;
    logic [1:0]  r_order, n_order;

    // working terms
    logic [DW-1:0] r_p1, n_p1;
    logic [DW-1:0] r_p2, n_p2;
    logic [SW-1:0] r_sum, n_sum;
    logic [DW-1:0] r_nmag, n_nmag;
    logic          r_nneg, n_nneg;
    logic [DW-1:0] r_den, n_den;
    logic [DW-1:0] r_u, n_u;
    logic [DW-1:0] r_v, n_v;
    logic [DW-1:0] r_g, n_g;
    logic [DW-1:0] r_x, n_x;
    logic [DW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;

    // output register
    logic        r_oval, n_oval;
    logic [31:0] r_onum, n_onum;
    logic [30:0] r_oden, n_oden;
    logic [1:0]  r_oord, n_oord;
    logic [1:0]  r_ost, n_ost;

    // shared units
    logic [31:0]   mul_a, mul_b;
    logic [DW-1:0] prod;
    logic [SW-1:0] au_x, au_y, au_sum;
    logic          au_sub, au_neg;

    logic          in_fire;
    logic          u_ge;
    logic [DW:0]   div_t;
    logic          div_bit;
    logic [DW-1:0] div_rem;
    logic [DW-1:0] gval;

    rat_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    rat_addsub u_alu (
        .i_x   (au_x),
        .i_y   (au_y),
        .i_sub (au_sub),
        .o_sum (au_sum),
        .o_neg (au_neg)
    );

    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign u_ge    = (r_u >= r_v);
    assign div_t   = {r_rem, r_x[DW-1]};
    assign div_bit = !au_neg;
    assign div_rem = div_bit ? au_sum[DW-1:0] : div_t[DW-1:0];
    assign gval    = r_u | r_v;

    // multiplier operand selection
    always_comb begin
        mul_a = r_amag;
        mul_b = {1'b0, r_d};
        case (r_state)
            S_M1: begin
                mul_a = r_amag;
                mul_b = (r_op == OP_MUL) ? r_cmag : {1'b0, r_d};
            end
            S_M2: begin
                mul_a = {1'b0, r_acc_den};
                mul_b = (r_op == OP_MUL) ? {1'b0, r_d} : r_cmag;
            end
            S_M3: begin
                mul_a = {1'b0, r_acc_den};
                mul_b = {1'b0, r_d};
            end
            default: begin
                mul_a = r_amag;
                mul_b = {1'b0, r_d};
            end
        endcase
    end

    // add/sub unit operand selection
    always_comb begin
        au_x   = SW'(r_p1);
        au_y   = SW'(r_p2);
        au_sub = 1'b1;
        case (r_state)
            S_SUM: begin
                au_x   = SW'(r_p1);
                au_y   = SW'(r_p2);
                // second term sign: operand sign, flipped for subtract and compare
                au_sub = (r_aneg != ((r_op == OP_ADD) ? r_cneg : !r_cneg));
            end
            S_NEG: begin
                au_x   = '0;
                au_y   = r_sum;
                au_sub = 1'b1;
            end
            S_GCD: begin
                au_x   = SW'(u_ge ? r_u : r_v);
                au_y   = SW'(u_ge ? r_v : r_u);
                au_sub = 1'b1;
            end
            S_DIVN, S_DIVD: begin
                au_x   = SW'(div_t);
                au_y   = SW'(r_g);
                au_sub = 1'b1;
            end
            default: begin
                au_x   = SW'(r_p1);
                au_y   = SW'(r_p2);
                au_sub = 1'b1;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_acc_num = r_acc_num;
        n_acc_den = r_acc_den;
        n_op      = r_op;
        n_cmag    = r_cmag;
        n_cneg    = r_cneg;
        n_d       = r_d;
        n_amag    = r_amag;
        n_aneg    = r_aneg;
        n_st      = r_st;
        n_order   = r_order;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_sum     = r_sum;
        n_nmag    = r_nmag;
        n_nneg    = r_nneg;
        n_den     = r_den;
        n_u       = r_u;
        n_v       = r_v;
        n_g       = r_g;
        n_x       = r_x;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_oval    = r_oval && !i_ready;
        n_onum    = r_onum;
        n_oden    = r_oden;
        n_oord    = r_oord;
        n_ost     = r_ost;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_opcode;
                    n_cneg  = i_operand_num[31];
                    n_cmag  = i_operand_num[31] ? (32'd0 - i_operand_num) : i_operand_num;
                    n_d     = (i_operand_den == '0) ? 31'd1 : i_operand_den;
                    n_st    = (i_operand_den == '0) ? ST_ZDEN : ST_OK;
                    n_order = ORD_EQ;
                    n_aneg  = r_acc_num[31];
                    n_amag  = r_acc_num[31] ? (32'd0 - r_acc_num) : r_acc_num;
                    case (i_opcode)
                        OP_LOAD: begin
                            n_nmag  = DW'(n_cmag);
                            n_nneg  = n_cneg;
                            n_den   = DW'(n_d);
                            n_state = S_RED;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_CMP: n_state = S_M1;
                        OP_DIV: begin
                            if (i_operand_num == '0) begin
                                n_st    = ST_DIVZ;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_M1;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_M1: n_state = S_M2;
            S_M2: begin
                n_p1    = prod;
                n_state = S_M3;
            end
            S_M3: begin
                if (r_op == OP_MUL || r_op == OP_DIV) begin
                    n_nmag  = r_p1;
                    n_nneg  = r_aneg ^ r_cneg;
                    n_den   = prod;
                    n_state = S_RED;
                end else begin
                    n_p2    = prod;
                    n_state = (r_op == OP_CMP) ? S_SUM : S_M4;
                end
            end
            S_M4: begin
                n_den   = prod;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum   = au_sum;
                n_state = S_NEG;
            end
            // magnitude and sign of the combined numerator
            S_NEG: begin
                n_nmag = r_sum[SW-1] ? au_sum[DW-1:0] : r_sum[DW-1:0];
                n_nneg = r_aneg ^ r_sum[SW-1];
                if (r_op == OP_CMP) begin
                    if (r_sum == '0)
                        n_order = ORD_EQ;
                    else
                        n_order = (r_aneg ^ r_sum[SW-1]) ? ORD_LT : ORD_GT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (r_nmag == '0) begin
                    n_acc_num = '0;
                    n_acc_den = 31'd1;
                    n_state   = S_DONE;
                end else begin
                    n_u     = r_nmag;
                    n_v     = r_den;
                    n_state = S_GCD;
                end
            end
            // binary gcd; common factors of two come straight off the terms
            S_GCD: begin
                if (r_u == '0 || r_v == '0) begin
                    n_g = gval;
                    if (gval == DW'(1)) begin
                        n_state = S_CHK;
                    end else begin
                        n_x     = r_nmag;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIVN;
                    end
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u    = r_u >> 1;
                    n_v    = r_v >> 1;
                    n_nmag = r_nmag >> 1;
                    n_den  = r_den >> 1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (u_ge) begin
                    n_u = au_sum[DW-1:0];
                end else begin
                    n_v = au_sum[DW-1:0];
                end
            end
            // restoring division of the numerator by the gcd
            S_DIVN: begin
                n_rem = div_rem;
                n_x   = {r_x[DW-2:0], div_bit};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    n_nmag  = {r_x[DW-2:0], div_bit};
                    n_x     = r_den;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVD;
                end
            end
            // and of the denominator
            S_DIVD: begin
                n_rem = div_rem;
                n_x   = {r_x[DW-2:0], div_bit};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    n_den   = {r_x[DW-2:0], div_bit};
                    n_state = S_CHK;
                end
            end
            // range check and commit
            S_CHK: begin
                if (r_nmag > LIM || r_den > LIM) begin
                    n_st = ST_OVF;
                end else begin
                    n_acc_num = r_nneg ? (32'd0 - r_nmag[31:0]) : r_nmag[31:0];
                    n_acc_den = r_den[30:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_oval || i_ready) begin
                    n_oval  = 1'b1;
                    n_onum  = r_acc_num;
                    n_oden  = r_acc_den;
                    n_oord  = r_order;
                    n_ost   = r_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc_num <= '0;
            r_acc_den <= 31'd1;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc_num <= n_acc_num;
            r_acc_den <= n_acc_den;
            r_oval    <= n_oval;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cmag  <= n_cmag;
        r_cneg  <= n_cneg;
        r_d     <= n_d;
        r_amag  <= n_amag;
        r_aneg  <= n_aneg;
        r_st    <= n_st;
        r_order <= n_order;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_sum   <= n_sum;
        r_nmag  <= n_nmag;
        r_nneg  <= n_nneg;
        r_den   <= n_den;
        r_u     <= n_u;
        r_v     <= n_v;
        r_g     <= n_g;
        r_x     <= n_x;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_onum  <= n_onum;
        r_oden  <= n_oden;
        r_oord  <= n_oord;
        r_ost   <= n_ost;
    end

    assign o_valid      = r_oval;
    assign o_result_num = r_onum;
    assign o_result_den = r_oden;
    assign o_order      = r_oord;
    assign o_status     = r_ost;

endmodule
